>>> src/plist_pkg.sv
`timescale 1ns / 1ps

package plist_pkg;

  // Field widths of one input item and one result item.
  localparam int CMD_W = 2;
  localparam int POS_W = 9;
  localparam int VAL_W = 64;
  localparam int ST_W  = 2;
  localparam int LEN_W = 9;

  // Default list capacity.
  localparam int DEF_CAPACITY = 256;

  // Fan-in of one level of the read-out tree.
  localparam int TREE_RADIX = 16;

  // Command codes; the unused code behaves as a read.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [ST_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [ST_W-1:0] STAT_OUTSIDE = 2'd2;

  // Operation broadcast to every cell.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ERASE
  } cell_op_t;

  // Control bundle shared by the whole row of cells.
  typedef struct packed {
    cell_op_t         op;
    logic             rd_en;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_RESP
  } state_t;

endpackage

>>> src/plist_if.sv
`timescale 1ns / 1ps

// Command channel.
interface plist_in_if import plist_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink (input valid, command, position, value, output ready);
endinterface

// Result channel.
interface plist_out_if import plist_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [ST_W-1:0]         status;
  logic [LEN_W-1:0]        length;

  modport source (output valid, read_value, status, length, input ready);
  modport sink (input valid, read_value, status, length, output ready);
endinterface

>>> src/plist_cell.sv
`timescale 1ns / 1ps

module plist_cell import plist_pkg::*; #(
  parameter int IDX_W = 8
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] left_data,
  input  logic [VAL_W-1:0] right_data,
  output logic [VAL_W-1:0] data,
  output logic [VAL_W-1:0] rd_data
);

  localparam int CW = (IDX_W > POS_W) ? IDX_W : POS_W;

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;
  logic [CW-1:0]    idx_ext;
  logic [CW-1:0]    pos_ext;

  assign idx_ext = CW'(idx);
  assign pos_ext = CW'(ctrl.pos);

  // Insert opens a gap at the position; erase closes the gap there.
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (idx_ext == pos_ext) begin
          data_nxt = ctrl.value;
        end else if (idx_ext > pos_ext) begin
          data_nxt = left_data;
        end
      end
      OP_ERASE: begin
        if (idx_ext >= pos_ext) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

  // Only the addressed cell drives the read-out tree.
  assign rd_data = (ctrl.rd_en && (idx_ext == pos_ext)) ? data_r : '0;

endmodule

>>> src/plist_or_tree.sv
`timescale 1ns / 1ps

module plist_or_tree import plist_pkg::*; #(
  parameter int N = 16,
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic [W-1:0] in_data [N],
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  localparam int G = (N + TREE_RADIX - 1) / TREE_RADIX;

  logic [W-1:0] grp_r [G];
  logic         vld_r;

  // Valid flag travels with the partial results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_valid;
    end
  end

  // One registered OR per group of inputs.
  for (genvar g = 0; g < G; g++) begin : g_grp
    localparam int LO  = g * TREE_RADIX;
    localparam int CNT = ((N - LO) < TREE_RADIX) ? (N - LO) : TREE_RADIX;

    logic [W-1:0] grp_nxt;

    always_comb begin
      grp_nxt = '0;
      for (int k = 0; k < CNT; k++) begin
        grp_nxt = grp_nxt | in_data[LO + k];
      end
    end

    always_ff @(posedge clk) begin
      grp_r[g] <= grp_nxt;
    end
  end

  // Further levels until a single group is left.
  if (G == 1) begin : g_last
    assign out_valid = vld_r;
    assign out_data  = grp_r[0];
  end else begin : g_next
    plist_or_tree #(
      .N(G),
      .W(W)
    ) u_next (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld_r),
      .in_data  (grp_r),
      .out_valid(out_valid),
      .out_data (out_data)
    );
  end

endmodule

>>> src/positional_list_engine.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 64-bit values addressed by position,
// held in a row of cells, one entry per cell. Each item is an insert, an erase
// or a read and yields exactly one result item carrying a status and the list
// length after the command. Insert and erase move every affected cell at once,
// so their result appears in the cycle after the item is accepted. A read goes
// through the issue and wait states and a registered OR tree of radix 16 before
// its result appears. The block holds one item at a time: a new item can be
// accepted in the cycle after the previous result has been taken. Commands
// that fail (full list, position outside the list) change nothing and finish
// as fast as an insert. Entries need no clearing after reset; only positions
// below the length are ever read.
module positional_list_engine import plist_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic clk,
  input  logic rst_n,
  plist_in_if.sink    in_chan,
  plist_out_if.source out_chan
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [VAL_W-1:0] read_value_r, read_value_nxt;
  logic [ST_W-1:0]  status_r, status_nxt;
  logic [LEN_W-1:0] length_r, length_nxt;

  cell_ctrl_t       ctrl;
  logic             in_fire;
  logic             out_fire;
  logic             tree_in_valid;
  logic             tree_out_valid;
  logic [VAL_W-1:0] tree_out_data;
  logic [VAL_W-1:0] cell_q  [CAPACITY];
  logic [VAL_W-1:0] cell_rd [CAPACITY];

  logic [CW-1:0]    pos_ext;
  logic [CW-1:0]    cnt_ext;
  logic [CW-1:0]    len_ext;
  logic             list_full;
  logic             in_list;
  logic [POS_W-1:0] ins_pos;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;

  // Position checks against the current length.
  assign pos_ext   = CW'(in_chan.position);
  assign cnt_ext   = CW'(count_r);
  assign list_full = (count_r == CNT_W'(CAPACITY));
  assign in_list   = (pos_ext < cnt_ext);
  assign ins_pos   = (pos_ext > cnt_ext) ? POS_W'(cnt_ext) : in_chan.position;
  assign len_ext   = CW'(count_nxt);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_chan.command == CMD_INSERT) || (in_chan.command == CMD_ERASE) ||
              !in_list) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (tree_out_valid) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake and cell control outputs.
  always_comb begin
    in_chan.ready  = 1'b0;
    out_chan.valid = 1'b0;
    tree_in_valid  = 1'b0;
    ctrl.op        = OP_HOLD;
    ctrl.rd_en     = 1'b0;
    ctrl.pos       = pos_r;
    ctrl.value     = in_chan.value;
    case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          if ((in_chan.command == CMD_INSERT) && !list_full) begin
            ctrl.op  = OP_INSERT;
            ctrl.pos = ins_pos;
          end else if ((in_chan.command == CMD_ERASE) && in_list) begin
            ctrl.op  = OP_ERASE;
            ctrl.pos = in_chan.position;
          end
        end
      end
      S_ISSUE: begin
        ctrl.rd_en    = 1'b1;
        tree_in_valid = 1'b1;
      end
      S_WAIT: ctrl.rd_en = 1'b0;
      S_RESP: out_chan.valid = 1'b1;
      default: in_chan.ready = 1'b0;
    endcase
  end

  // Length, latched position and result fields.
  always_comb begin
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    read_value_nxt = read_value_r;
    status_nxt     = status_r;
    if ((state_r == S_IDLE) && in_fire) begin
      pos_nxt        = in_chan.position;
      read_value_nxt = '0;
      status_nxt     = STAT_DONE;
      case (in_chan.command)
        CMD_INSERT: begin
          if (list_full) begin
            status_nxt = STAT_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_ERASE: begin
          if (!in_list) begin
            status_nxt = STAT_OUTSIDE;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          if (!in_list) begin
            status_nxt = STAT_OUTSIDE;
          end
        end
      endcase
    end else if ((state_r == S_WAIT) && tree_out_valid) begin
      read_value_nxt = tree_out_data;
    end
    length_nxt = len_ext[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    read_value_r <= read_value_nxt;
    status_r     <= status_nxt;
    length_r     <= length_nxt;
  end

  assign out_chan.read_value = read_value_r;
  assign out_chan.status     = status_r;
  assign out_chan.length     = length_r;

  // Row of cells; each takes from its left neighbor on insert, right on erase.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_d;
    logic [VAL_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    plist_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctrl      (ctrl),
      .left_data (left_d),
      .right_data(right_d),
      .data      (cell_q[i]),
      .rd_data   (cell_rd[i])
    );
  end

  // Read-out of the addressed cell.
  plist_or_tree #(
    .N(CAPACITY),
    .W(VAL_W)
  ) u_tree (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (tree_in_valid),
    .in_data  (cell_rd),
    .out_valid(tree_out_valid),
    .out_data (tree_out_data)
  );

  // The length never goes past the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  // A successful insert grows the list by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_chan.command == CMD_INSERT) && !list_full)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the list");

  // Tree output arrives only while a read waits for it.
  a_tree_timing: assert property (@(posedge clk) disable iff (!rst_n)
    tree_out_valid |-> (state_r == S_WAIT))
    else $error("read-out tree result outside wait state");

  // Failed commands report a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status != STAT_DONE)) |-> (out_chan.read_value == '0))
    else $error("failed command carries a value");

endmodule
